>>> rtl/cau_pkg.sv
`default_nettype none
package cau_pkg;

	localparam int DATA_W   = 32;
	localparam int FRAC_W   = 16;
	localparam int PROD_W   = 2 * DATA_W;
	localparam int WIDE_W   = PROD_W + 1;
	localparam int ROOT_W   = DATA_W;
	// one root bit resolved per square-root stage
	localparam int SQ_STEPS = ROOT_W;

	typedef enum logic [2:0] {
		FUNC_ADD  = 3'd0,
		FUNC_SUB  = 3'd1,
		FUNC_RE   = 3'd2,
		FUNC_IM   = 3'd3,
		FUNC_CMUL = 3'd4,
		FUNC_MAG  = 3'd5
	} func_e;

	typedef struct packed {
		logic [2:0]               func;
		logic signed [DATA_W-1:0] a_re;
		logic signed [DATA_W-1:0] a_im;
		logic signed [DATA_W-1:0] b_re;
		logic signed [DATA_W-1:0] b_im;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] res_re;
		logic signed [DATA_W-1:0] res_im;
		logic                     overflow;
	} rsp_t;

	localparam logic signed [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

	// saturate a wide signed value to the word range; bit DATA_W is the overflow flag
	function automatic logic [DATA_W:0] sat_word(input logic signed [WIDE_W-1:0] v);
		logic [WIDE_W-DATA_W:0] top;
		top = v[WIDE_W-1:DATA_W-1];
		if (top == '0 || top == '1) begin
			sat_word = {1'b0, v[DATA_W-1:0]};
		end else if (v[WIDE_W-1]) begin
			sat_word = {1'b1, MIN_VAL};
		end else begin
			sat_word = {1'b1, MAX_VAL};
		end
	endfunction

endpackage
`default_nettype wire

>>> rtl/complex_arith_unit_top.sv
// Throughput: one request per cycle while the result register is not held;
// the 32-stage square-root chain and four 32x32 multipliers are fully
// pipelined, every operation takes the same path.
// Stalls freeze the whole pipeline at once; nothing is dropped or repeated.
// Reset (arst_n low, asynchronous) clears all valid bits; payload is not reset.
`default_nettype none
module complex_arith_unit_top (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire cau_pkg::req_t   req,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output cau_pkg::rsp_t        rsp
);

	localparam int DW = cau_pkg::DATA_W;
	localparam int PW = cau_pkg::PROD_W;
	localparam int WW = cau_pkg::WIDE_W;
	localparam int RW = cau_pkg::ROOT_W;
	localparam int NS = cau_pkg::SQ_STEPS;

	logic adv;
	logic out_valid_q;
	cau_pkg::rsp_t out_q;
	logic out_mag_q;

	// whole pipeline moves unless the result register is held
	assign adv       = !(out_valid_q && rsp_stall);
	assign req_stall = !adv;

	// ---------------- stage 1: multipliers and add/sub
	logic                 v_s1;
	logic [2:0]           func_s1;
	logic signed [PW-1:0] m0_s1, m1_s1, m2_s1, m3_s1;
	logic signed [DW:0]   sre_s1, sim_s1;

	logic signed [DW-1:0] op0, op1;
	logic is_mag_in, is_sub_in;
	assign is_mag_in = (req.func == cau_pkg::FUNC_MAG);
	assign is_sub_in = (req.func == cau_pkg::FUNC_SUB);
	assign op0 = is_mag_in ? req.a_re : req.b_re;
	assign op1 = is_mag_in ? req.a_im : req.b_im;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= req.func;
			m0_s1   <= PW'(req.a_re) * PW'(op0);
			m1_s1   <= PW'(req.a_im) * PW'(op1);
			m2_s1   <= PW'(req.a_re) * PW'(req.b_im);
			m3_s1   <= PW'(req.a_im) * PW'(req.b_re);
			sre_s1  <= is_sub_in ? (DW+1)'(req.a_re) - (DW+1)'(req.b_re)
			                     : (DW+1)'(req.a_re) + (DW+1)'(req.b_re);
			sim_s1  <= is_sub_in ? (DW+1)'(req.a_im) - (DW+1)'(req.b_im)
			                     : (DW+1)'(req.a_im) + (DW+1)'(req.b_im);
		end
	end

	// ---------------- stage 2: combine products
	logic                 v_s2, shift_s2, mag_s2;
	logic signed [WW-1:0] wre_s2, wim_s2;
	logic [PW-1:0]        n_s2;

	logic signed [WW-1:0] wre_c, wim_c, e0, e1, e2, e3;
	logic shift_c;
	assign e0 = WW'(m0_s1);
	assign e1 = WW'(m1_s1);
	assign e2 = WW'(m2_s1);
	assign e3 = WW'(m3_s1);

	always_comb begin
		wre_c   = '0;
		wim_c   = '0;
		shift_c = 1'b0;
		case (func_s1)
			cau_pkg::FUNC_ADD, cau_pkg::FUNC_SUB: begin
				wre_c = WW'(sre_s1);
				wim_c = WW'(sim_s1);
			end
			cau_pkg::FUNC_RE: begin
				wre_c   = e0;
				wim_c   = e3;
				shift_c = 1'b1;
			end
			cau_pkg::FUNC_IM: begin
				wre_c   = -e1;
				wim_c   = e2;
				shift_c = 1'b1;
			end
			cau_pkg::FUNC_CMUL: begin
				wre_c   = e0 - e1;
				wim_c   = e2 + e3;
				shift_c = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wre_s2   <= wre_c;
			wim_s2   <= wim_c;
			shift_s2 <= shift_c;
			mag_s2   <= (func_s1 == cau_pkg::FUNC_MAG);
			// both squares are non-negative and their sum fits 64 bits unsigned
			n_s2     <= $unsigned(m0_s1) + $unsigned(m1_s1);
		end
	end

	// ---------------- stage 3: truncate and saturate, feed square root
	logic                 sq_v   [NS+1];
	logic                 sq_mag [NS+1];
	logic [DW-1:0]        sq_re  [NS+1];
	logic [DW-1:0]        sq_im  [NS+1];
	logic                 sq_ovf [NS+1];
	logic [PW-1:0]        sq_rem [NS+1];
	logic [RW-1:0]        sq_root[NS+1];

	logic signed [WW-1:0] tre, tim;
	logic [DW:0]          satre, satim;
	assign tre   = shift_s2 ? (wre_s2 >>> cau_pkg::FRAC_W) : wre_s2;
	assign tim   = shift_s2 ? (wim_s2 >>> cau_pkg::FRAC_W) : wim_s2;
	assign satre = cau_pkg::sat_word(tre);
	assign satim = cau_pkg::sat_word(tim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v[0] <= 1'b0;
		end else if (adv) begin
			sq_v[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_mag[0]  <= mag_s2;
			sq_re[0]   <= satre[DW-1:0];
			sq_im[0]   <= satim[DW-1:0];
			sq_ovf[0]  <= satre[DW] | satim[DW];
			sq_rem[0]  <= n_s2;
			sq_root[0] <= '0;
		end
	end

	// ---------------- square-root chain: one root bit per stage
	for (genvar i = 0; i < NS; i++) begin : g_sq
		localparam int K = NS - 1 - i;
		logic [PW-1:0] trial;
		logic          take;
		assign trial = (PW'(sq_root[i]) << (K + 1)) | (PW'(1) << (2 * K));
		assign take  = (sq_rem[i] >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[i+1] <= 1'b0;
			end else if (adv) begin
				sq_v[i+1] <= sq_v[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_mag[i+1]  <= sq_mag[i];
				sq_re[i+1]   <= sq_re[i];
				sq_im[i+1]   <= sq_im[i];
				sq_ovf[i+1]  <= sq_ovf[i];
				sq_rem[i+1]  <= take ? sq_rem[i] - trial : sq_rem[i];
				sq_root[i+1] <= take ? (sq_root[i] | (RW'(1) << K)) : sq_root[i];
			end
		end
	end

	// ---------------- result register
	logic root_big;
	assign root_big = sq_root[NS][RW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= sq_v[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_mag_q <= sq_mag[NS];
			if (sq_mag[NS]) begin
				out_q.res_re   <= root_big ? cau_pkg::MAX_VAL : sq_root[NS];
				out_q.res_im   <= '0;
				out_q.overflow <= root_big;
			end else begin
				out_q.res_re   <= sq_re[NS];
				out_q.res_im   <= sq_im[NS];
				out_q.overflow <= sq_ovf[NS];
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// ---------------- checks
	a_mag_im_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && out_mag_q) |-> (rsp.res_im == '0))
		else $error("magnitude result with nonzero imaginary part");

	a_ovf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.overflow) |->
		(rsp.res_re == cau_pkg::MAX_VAL || rsp.res_re == cau_pkg::MIN_VAL ||
		 rsp.res_im == cau_pkg::MAX_VAL || rsp.res_im == cau_pkg::MIN_VAL))
		else $error("overflow flagged without a saturated part");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv) |=> ($stable(sq_v[NS]) && $stable(v_s1) && $stable(sq_root[NS])))
		else $error("pipeline moved while stalled");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> v_s1)
		else $error("accepted request not captured");

endmodule
`default_nettype wire
